// ===== sv/pcbe_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbe_pkg
// Shared codes, widths and control types of the piecewise cubic Bezier
// evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcbe_pkg;

  // Fixed field widths of the stream ports
  localparam int SEGIDX_W = 6;   // segment index of a load beat
  localparam int CNT_W    = 7;   // segment count register

  // Growth of coefficients and the Horner accumulator over a coordinate
  localparam int CF_GROW  = 4;
  localparam int ACC_GROW = 5;

  // Beat kind carried on in_tuser
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // Control that the front end hands to every lane
  typedef struct packed {
    logic advance;  // pipeline moves one stage, coefficient read issues
    logic load;     // write the converted coefficients of this beat
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/pcbe_ram.sv =====
// ----------------------------------------------------------------------------
// pcbe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/pcbe_lane.sv =====
// ----------------------------------------------------------------------------
// pcbe_lane
// One coordinate axis: converts control points to power-basis coefficients,
// keeps them in a per-segment RAM row and evaluates the cubic by Horner's
// rule in a six-stage multiply / round-add pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbe_lane #(
  parameter int COORD_BITS   = 24,
  parameter int TIME_BITS    = 16,
  parameter int MAX_SEGMENTS = 64,
  parameter int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  wire logic                                          clk,
  input  wire pcbe_pkg::lane_ctl_t                           ctl,
  input  wire logic [SEG_W-1:0]                              wr_addr,
  input  wire logic [SEG_W-1:0]                              rd_addr,
  input  wire logic signed [COORD_BITS-1:0]                  p0,
  input  wire logic signed [COORD_BITS-1:0]                  p1,
  input  wire logic signed [COORD_BITS-1:0]                  p2,
  input  wire logic signed [COORD_BITS-1:0]                  p3,
  input  wire logic [TIME_BITS-1:0]                          u,
  output logic signed [COORD_BITS+pcbe_pkg::ACC_GROW-1:0]    acc
);

  import pcbe_pkg::*;

  localparam int CF_W   = COORD_BITS + CF_GROW;
  localparam int ACC_W  = COORD_BITS + ACC_GROW;
  localparam int PW     = ACC_W + TIME_BITS + 1;
  localparam int ROW_W  = 4 * CF_W;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TIME_BITS - 1);

  // Power-basis conversion of the four control points
  logic signed [CF_W-1:0] e0, e1, e2, e3;
  logic signed [CF_W-1:0] d10, d012, d12;
  logic signed [CF_W-1:0] k0, k1, k2, k3;

  always_comb begin
    e0   = {{CF_GROW{p0[COORD_BITS-1]}}, p0};
    e1   = {{CF_GROW{p1[COORD_BITS-1]}}, p1};
    e2   = {{CF_GROW{p2[COORD_BITS-1]}}, p2};
    e3   = {{CF_GROW{p3[COORD_BITS-1]}}, p3};
    d10  = e1 - e0;
    d012 = e0 - (e1 <<< 1) + e2;
    d12  = e1 - e2;
    k0   = e0;
    k1   = d10 + (d10 <<< 1);
    k2   = d012 + (d012 <<< 1);
    k3   = e3 - e0 + d12 + (d12 <<< 1);
  end

  // Coefficient RAM, one row per segment: {c3, c2, c1, c0}
  logic [ROW_W-1:0] row;

  pcbe_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SEGMENTS),
    .AW    (SEG_W)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ctl.load),
    .waddr (wr_addr),
    .wdata ({k3, k2, k1, k0}),
    .re    (ctl.advance),
    .raddr (rd_addr),
    .rdata (row)
  );

  logic signed [CF_W-1:0] c0, c1, c2, c3;
  assign c0 = row[0*CF_W +: CF_W];
  assign c1 = row[1*CF_W +: CF_W];
  assign c2 = row[2*CF_W +: CF_W];
  assign c3 = row[3*CF_W +: CF_W];

  // Pipeline registers
  logic [TIME_BITS-1:0]   u0_r, u1_r, u2_r, u3_r, u4_r;
  logic signed [PW-1:0]   prod1_r, prod2_r, prod3_r;
  logic signed [ACC_W-1:0] acc1_r, acc2_r, acc3_r;
  logic signed [CF_W-1:0] c2_1_r, c1_1_r, c0_1_r;
  logic signed [CF_W-1:0] c1_2_r, c0_2_r;
  logic signed [CF_W-1:0] c1_3_r, c0_3_r;
  logic signed [CF_W-1:0] c0_4_r, c0_5_r;

  logic signed [PW-1:0]    prod1_nxt, prod2_nxt, prod3_nxt;
  logic signed [PW-1:0]    rnd1, rnd2, rnd3;
  logic signed [ACC_W-1:0] acc1_nxt, acc2_nxt, acc3_nxt;
  logic signed [ACC_W-1:0] c3_ext;

  // Multiply by local time, then round to nearest (ties up) and add
  always_comb begin
    c3_ext    = {{(ACC_W-CF_W){c3[CF_W-1]}}, c3};
    prod1_nxt = c3_ext * $signed({1'b0, u0_r});
    rnd1      = prod1_r + HALF;
    acc1_nxt  = rnd1[TIME_BITS +: ACC_W] + {{(ACC_W-CF_W){c2_1_r[CF_W-1]}}, c2_1_r};
    prod2_nxt = acc1_r * $signed({1'b0, u2_r});
    rnd2      = prod2_r + HALF;
    acc2_nxt  = rnd2[TIME_BITS +: ACC_W] + {{(ACC_W-CF_W){c1_3_r[CF_W-1]}}, c1_3_r};
    prod3_nxt = acc2_r * $signed({1'b0, u4_r});
    rnd3      = prod3_r + HALF;
    acc3_nxt  = rnd3[TIME_BITS +: ACC_W] + {{(ACC_W-CF_W){c0_5_r[CF_W-1]}}, c0_5_r};
  end

  // Advance all stages together; hold on stall
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      u0_r    <= u;
      // stage 1: c3 * u
      prod1_r <= prod1_nxt;
      c2_1_r  <= c2;
      c1_1_r  <= c1;
      c0_1_r  <= c0;
      u1_r    <= u0_r;
      // stage 2: round + c2
      acc1_r  <= acc1_nxt;
      c1_2_r  <= c1_1_r;
      c0_2_r  <= c0_1_r;
      u2_r    <= u1_r;
      // stage 3: acc * u
      prod2_r <= prod2_nxt;
      c1_3_r  <= c1_2_r;
      c0_3_r  <= c0_2_r;
      u3_r    <= u2_r;
      // stage 4: round + c1
      acc2_r  <= acc2_nxt;
      c0_4_r  <= c0_3_r;
      u4_r    <= u3_r;
      // stage 5: acc * u
      prod3_r <= prod3_nxt;
      c0_5_r  <= c0_4_r;
      // stage 6: round + c0
      acc3_r  <= acc3_nxt;
    end
  end

  assign acc = acc3_r;

endmodule

`default_nettype wire

// ===== sv/pcbe_merge.sv =====
// ----------------------------------------------------------------------------
// pcbe_merge
// Joins the x and y lanes: saturates each coordinate, flags clipping and
// holds the finished point in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcbe_merge #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       push,
  input  wire logic signed [COORD_BITS+pcbe_pkg::ACC_GROW-1:0] acc_x,
  input  wire logic signed [COORD_BITS+pcbe_pkg::ACC_GROW-1:0] acc_y,
  input  wire logic                                       out_tready,
  output logic                                            out_tvalid,
  output logic signed [COORD_BITS-1:0]                    curve_x,
  output logic signed [COORD_BITS-1:0]                    curve_y,
  output logic                                            clipped
);

  import pcbe_pkg::*;

  localparam int ACC_W = COORD_BITS + ACC_GROW;
  localparam int TOP_W = ACC_W - COORD_BITS + 1;

  logic                  valid_r;
  logic [COORD_BITS-1:0] x_r, y_r, x_nxt, y_nxt;
  logic                  clip_r;
  logic                  ovf_x, ovf_y;

  // Saturate to the signed coordinate range
  always_comb begin
    ovf_x = acc_x[ACC_W-1:COORD_BITS-1] != {TOP_W{acc_x[ACC_W-1]}};
    ovf_y = acc_y[ACC_W-1:COORD_BITS-1] != {TOP_W{acc_y[ACC_W-1]}};
    x_nxt = ovf_x ? {acc_x[ACC_W-1], {(COORD_BITS-1){~acc_x[ACC_W-1]}}}
                  : acc_x[COORD_BITS-1:0];
    y_nxt = ovf_y ? {acc_y[ACC_W-1], {(COORD_BITS-1){~acc_y[ACC_W-1]}}}
                  : acc_y[COORD_BITS-1:0];
  end

  // Output valid: set on push, else drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (push) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      clip_r <= ovf_x | ovf_y;
    end
  end

  assign out_tvalid = valid_r;
  assign curve_x    = x_r;
  assign curve_y    = y_r;
  assign clipped    = clip_r;

endmodule

`default_nettype wire

// ===== sv/piecewise_cubic_bezier_eval.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_bezier_eval
// Evaluates a path of cubic Bezier segments, x and y in two parallel lanes.
// ----------------------------------------------------------------------------
// One beat per cycle is taken on the input stream while not stalled. A load
// beat (tuser 0) converts four control points to power-basis coefficients
// and writes one row of each lane's coefficient RAM in the cycle it is
// accepted; it gives no output. An evaluate beat (tuser 1) splits
// sample_time*segment_count into a segment and a local time, reads the
// segment's row and runs each axis through three Horner steps, each a
// multiply stage and a round-add stage. Its point passes the RAM read at
// the accepting edge, six Horner stages and the output register; evaluates
// issue back to back, one per cycle. A load may be followed at once by an
// evaluate of the same segment. Evaluating a segment that was never loaded
// gives an unspecified point. The pipeline stalls only when its last stage
// holds a point and the output register is still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_cubic_bezier_eval #(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 24,
  parameter int TIME_BITS    = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,

  // tdata, low bit first: segment_index, point0_x, point0_y, point1_x,
  // point1_y, point2_x, point2_y, point3_x, point3_y, sample_time, zero pad
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire logic [((pcbe_pkg::SEGIDX_W + 8*COORD_BITS + TIME_BITS + 7) / 8) * 8 - 1:0]
                    in_tdata,
  input  wire logic in_tuser,   // opcode

  // tdata, low bit first: curve_x, curve_y, zero pad
  output logic      out_tvalid,
  input  wire logic out_tready,
  output logic [((2*COORD_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic      out_tuser,  // clipped

  // segment_count register
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [pcbe_pkg::CNT_W-1:0] cfg_data
);

  import pcbe_pkg::*;

  localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int ACC_W  = COORD_BITS + ACC_GROW;
  localparam int OUT_W  = ((2*COORD_BITS + 7) / 8) * 8;
  localparam int LAT    = 7;
  localparam int OFF_P  = SEGIDX_W;
  localparam int OFF_T  = SEGIDX_W + 8*COORD_BITS;
  localparam int PT_W   = TIME_BITS + CNT_W;

  // Segment count register, clamped on write
  logic [CNT_W-1:0] n_r, n_nxt;

  always_comb begin
    if (cfg_data == '0) begin
      n_nxt = CNT_W'(1);
    end else if (32'(cfg_data) > MAX_SEGMENTS) begin
      n_nxt = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= CNT_W'(1);
    end else if (cfg_valid) begin
      n_r <= n_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // Unpack the input beat
  logic [SEGIDX_W-1:0]           seg_idx;
  logic signed [COORD_BITS-1:0]  p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
  logic [TIME_BITS-1:0]          t_in;
  op_t                           op;

  assign seg_idx = in_tdata[SEGIDX_W-1:0];
  assign p0x     = in_tdata[OFF_P + 0*COORD_BITS +: COORD_BITS];
  assign p0y     = in_tdata[OFF_P + 1*COORD_BITS +: COORD_BITS];
  assign p1x     = in_tdata[OFF_P + 2*COORD_BITS +: COORD_BITS];
  assign p1y     = in_tdata[OFF_P + 3*COORD_BITS +: COORD_BITS];
  assign p2x     = in_tdata[OFF_P + 4*COORD_BITS +: COORD_BITS];
  assign p2y     = in_tdata[OFF_P + 5*COORD_BITS +: COORD_BITS];
  assign p3x     = in_tdata[OFF_P + 6*COORD_BITS +: COORD_BITS];
  assign p3y     = in_tdata[OFF_P + 7*COORD_BITS +: COORD_BITS];
  assign t_in    = in_tdata[OFF_T +: TIME_BITS];
  assign op      = op_t'(in_tuser);

  // Split global time into segment and local time
  logic [PT_W-1:0]      pt;
  logic [CNT_W-1:0]     seg_raw, seg_sel;
  logic [TIME_BITS-1:0] u;

  always_comb begin
    pt      = PT_W'(t_in) * PT_W'(n_r);
    seg_raw = pt[TIME_BITS +: CNT_W];
    seg_sel = (seg_raw >= n_r) ? (n_r - CNT_W'(1)) : seg_raw;
    u       = pt[TIME_BITS-1:0];
  end

  // Handshake and pipeline advance
  logic [LAT-1:0] v_r;
  logic           advance, accept, eval_acc;
  lane_ctl_t      ctl;

  always_comb begin
    advance      = !v_r[LAT-1] || !out_tvalid || out_tready;
    accept       = in_tvalid && advance;
    eval_acc     = accept && (op == OP_EVAL);
    ctl.advance  = advance;
    ctl.load     = accept && (op == OP_LOAD) && (32'(seg_idx) < MAX_SEGMENTS);
  end

  assign in_tready = advance;

  // Shift evaluate valids along the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[LAT-2:0], eval_acc};
    end
  end

  // Lanes
  logic [SEG_W-1:0]        wr_addr, rd_addr;
  logic signed [ACC_W-1:0] acc_x, acc_y;

  assign wr_addr = SEG_W'(seg_idx);
  assign rd_addr = SEG_W'(seg_sel);

  pcbe_lane #(
    .COORD_BITS   (COORD_BITS),
    .TIME_BITS    (TIME_BITS),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SEG_W        (SEG_W)
  ) u_lane_x (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .p0      (p0x),
    .p1      (p1x),
    .p2      (p2x),
    .p3      (p3x),
    .u       (u),
    .acc     (acc_x)
  );

  pcbe_lane #(
    .COORD_BITS   (COORD_BITS),
    .TIME_BITS    (TIME_BITS),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SEG_W        (SEG_W)
  ) u_lane_y (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .p0      (p0y),
    .p1      (p1y),
    .p2      (p2y),
    .p3      (p3y),
    .u       (u),
    .acc     (acc_y)
  );

  // Merge lanes into the output register
  logic [COORD_BITS-1:0] curve_x, curve_y;
  logic                  clipped;

  pcbe_merge #(
    .COORD_BITS (COORD_BITS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (advance && v_r[LAT-1]),
    .acc_x      (acc_x),
    .acc_y      (acc_y),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .curve_x    (curve_x),
    .curve_y    (curve_y),
    .clipped    (clipped)
  );

  assign out_tdata = OUT_W'({curve_y, curve_x});
  assign out_tuser = clipped;

endmodule

`default_nettype wire
